/* rtl/core/tts_pkg.sv */
package tts_pkg;

    // operation codes carried by the op field
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_LOAD     = 2'd2,
        OP_NOP      = 2'd3
    } op_t;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned SEL_W     = 3;
    localparam int unsigned INDEX_W   = 2;
    localparam int unsigned MASK_W    = 4;
    localparam logic [TIME_W-1:0] RELOAD_NONE = 32'hFFFF_FFFF;
    localparam logic [TIME_W-1:0] COUNT_FIRE  = 32'd1;

    // per-slot update strobes; tick, take and load are already qualified by pipeline advance
    typedef struct packed {
        logic tick;
        logic take;
        logic load;
        logic clear;
    } slot_ctl_t;

endpackage

/* rtl/core/tick_task_scheduler.sv */
// channel  | handshake               | payload
// ---------+-------------------------+--------------------------------------------------
// cmd      | cmd_valid / cmd_stall   | op, slot_sel, reload_value, countdown_value,
//          |                         | periodic, clear_pending
// rsp      | rsp_valid / rsp_stall   | task_valid, task_index, fired_mask
//
// one transaction per cycle sustained while rsp_stall is low; each passes the cmd register, then the rsp register
// the slot table is updated as a transaction moves from the cmd register to the rsp register
// reset clears all slots (reload, periodic flag, countdown, pending count) and both valids
// rsp_stall holds the rsp register and backs up through the cmd register to cmd_stall
module tick_task_scheduler #(
    parameter int unsigned NUM_TASKS     = 4,
    parameter int unsigned PENDING_WIDTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command channel
    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  logic [1:0]                          op,
    input  logic [tts_pkg::SEL_W-1:0]           slot_sel,
    input  logic [tts_pkg::TIME_W-1:0]          reload_value,
    input  logic [tts_pkg::TIME_W-1:0]          countdown_value,
    input  logic                                periodic,
    input  logic                                clear_pending,
    // response channel
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic                                task_valid,
    output logic [tts_pkg::INDEX_W-1:0]         task_index,
    output logic [tts_pkg::MASK_W-1:0]          fired_mask
);

    // command register
    logic                         cmd_valid_reg;
    logic                         cmd_valid_next;
    tts_pkg::op_t                 op_reg;
    logic [tts_pkg::SEL_W-1:0]    sel_reg;
    logic [tts_pkg::TIME_W-1:0]   reload_reg;
    logic [tts_pkg::TIME_W-1:0]   count_reg;
    logic                         periodic_reg;
    logic                         clear_reg;

    // response register
    logic                         rsp_valid_reg;
    logic                         rsp_valid_next;
    logic                         task_valid_reg;
    logic                         task_valid_next;
    logic [tts_pkg::INDEX_W-1:0]  task_index_reg;
    logic [tts_pkg::INDEX_W-1:0]  task_index_next;
    logic [tts_pkg::MASK_W-1:0]   fired_mask_reg;
    logic [tts_pkg::MASK_W-1:0]   fired_mask_next;

    logic                         rsp_free;
    logic                         advance;
    logic                         sel_in_range;
    logic [NUM_TASKS-1:0]         pend_nz;
    logic [NUM_TASKS-1:0]         fired_vec;
    logic [NUM_TASKS-1:0]         take_vec;
    logic                         found;
    logic [tts_pkg::SEL_W-1:0]    found_idx;

    // rsp register can take a new transaction when empty or being drained
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign advance   = cmd_valid_reg && rsp_free;
    assign cmd_stall = cmd_valid_reg && !rsp_free;

    assign sel_in_range = ({1'b0, sel_reg} < (tts_pkg::SEL_W + 1)'(NUM_TASKS));

    // lowest-numbered slot with pending runs wins
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        take_vec  = '0;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            if (pend_nz[i] && !found)
            begin
                found       = 1'b1;
                found_idx   = tts_pkg::SEL_W'(i);
                take_vec[i] = 1'b1;
            end
        end
    end

    // one slot per task, each advancing in parallel on a tick
    for (genvar g = 0; g < NUM_TASKS; g++)
    begin : g_slot
        tts_pkg::slot_ctl_t ctl;

        always_comb
        begin
            ctl.tick  = advance && (op_reg == tts_pkg::OP_TICK);
            ctl.take  = advance && (op_reg == tts_pkg::OP_DISPATCH) && take_vec[g];
            ctl.load  = advance && (op_reg == tts_pkg::OP_LOAD) && sel_in_range
                        && (sel_reg == tts_pkg::SEL_W'(g));
            ctl.clear = clear_reg;
        end

        tts_slot #(
            .PENDING_WIDTH (PENDING_WIDTH)
        ) u_slot (
            .clk             (clk),
            .rst_n           (rst_n),
            .ctl             (ctl),
            .reload_value    (reload_reg),
            .countdown_value (count_reg),
            .periodic        (periodic_reg),
            .pending_nz      (pend_nz[g]),
            .fired           (fired_vec[g])
        );
    end

    // slots past the fourth have no mask bit; missing slots read as zero
    logic [tts_pkg::MASK_W-1:0] fired_low;
    for (genvar m = 0; m < tts_pkg::MASK_W; m++)
    begin : g_mask
        if (m < NUM_TASKS)
        begin : g_on
            assign fired_low[m] = fired_vec[m];
        end
        else
        begin : g_off
            assign fired_low[m] = 1'b0;
        end
    end

    // result of the transaction in the cmd register
    always_comb
    begin
        task_valid_next = 1'b0;
        task_index_next = '0;
        fired_mask_next = '0;
        case (op_reg)
            tts_pkg::OP_TICK:
            begin
                fired_mask_next = fired_low;
            end
            tts_pkg::OP_DISPATCH:
            begin
                task_valid_next = found;
                task_index_next = found_idx[tts_pkg::INDEX_W-1:0];
            end
            default:
            begin
                task_valid_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (!cmd_stall)
        begin
            cmd_valid_next = cmd_valid;
        end
        rsp_valid_next = rsp_valid_reg;
        if (rsp_free)
        begin
            rsp_valid_next = cmd_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            op_reg       <= tts_pkg::op_t'(op);
            sel_reg      <= slot_sel;
            reload_reg   <= reload_value;
            count_reg    <= countdown_value;
            periodic_reg <= periodic;
            clear_reg    <= clear_pending;
        end
        if (advance)
        begin
            task_valid_reg <= task_valid_next;
            task_index_reg <= task_index_next;
            fired_mask_reg <= fired_mask_next;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign task_valid = task_valid_reg;
    assign task_index = task_index_reg;
    assign fired_mask = fired_mask_reg;

endmodule

/* rtl/core/tts_slot.sv */
module tts_slot #(
    parameter int unsigned PENDING_WIDTH = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tts_pkg::slot_ctl_t            ctl,
    input  logic [tts_pkg::TIME_W-1:0]    reload_value,
    input  logic [tts_pkg::TIME_W-1:0]    countdown_value,
    input  logic                          periodic,
    output logic                          pending_nz,
    output logic                          fired
);

    localparam logic [PENDING_WIDTH-1:0] PEND_MAX = {PENDING_WIDTH{1'b1}};

    logic [tts_pkg::TIME_W-1:0] reload_reg;
    logic [tts_pkg::TIME_W-1:0] reload_next;
    logic                       periodic_reg;
    logic                       periodic_next;
    logic [tts_pkg::TIME_W-1:0] count_reg;
    logic [tts_pkg::TIME_W-1:0] count_next;
    logic [PENDING_WIDTH-1:0]   pend_reg;
    logic [PENDING_WIDTH-1:0]   pend_next;
    logic                       at_fire;

    assign at_fire    = (count_reg == tts_pkg::COUNT_FIRE);
    assign pending_nz = (pend_reg != '0);
    // fires only on a tick at count one, periodic, and with room in the pending count
    assign fired      = ctl.tick && at_fire && periodic_reg && (pend_reg != PEND_MAX);

    always_comb
    begin
        reload_next   = reload_reg;
        periodic_next = periodic_reg;
        count_next    = count_reg;
        pend_next     = pend_reg;
        if (ctl.tick)
        begin
            if (at_fire)
            begin
                if (periodic_reg)
                begin
                    count_next = reload_reg;
                end
                if (fired)
                begin
                    pend_next = pend_reg + 1'b1;
                end
            end
            else
            begin
                // zero wraps to all ones
                count_next = count_reg - 1'b1;
            end
        end
        else if (ctl.take)
        begin
            pend_next = pend_reg - 1'b1;
        end
        else if (ctl.load)
        begin
            reload_next   = reload_value;
            periodic_next = periodic && (reload_value != tts_pkg::RELOAD_NONE);
            count_next    = countdown_value;
            if (ctl.clear)
            begin
                pend_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg   <= '0;
            periodic_reg <= 1'b0;
            count_reg    <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            reload_reg   <= reload_next;
            periodic_reg <= periodic_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
        end
    end

endmodule

/* test/tick_task_scheduler_check.sv */
module tick_task_scheduler_check #(
    parameter int unsigned NUM_TASKS     = 4,
    parameter int unsigned PENDING_WIDTH = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  logic                        cmd_stall,
    input  logic [1:0]                  op,
    input  logic [tts_pkg::SEL_W-1:0]   slot_sel,
    input  logic [tts_pkg::TIME_W-1:0]  reload_value,
    input  logic [tts_pkg::TIME_W-1:0]  countdown_value,
    input  logic                        periodic,
    input  logic                        clear_pending,
    input  logic                        rsp_valid,
    input  logic                        rsp_stall,
    input  logic                        task_valid,
    input  logic [tts_pkg::INDEX_W-1:0] task_index,
    input  logic [tts_pkg::MASK_W-1:0]  fired_mask,
    output int                          errors,
    output int                          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    localparam logic [PENDING_WIDTH-1:0] RUNS_FULL = '1;

    typedef struct packed {
        logic               task_valid;
        logic [INDEX_W-1:0] task_index;
        logic [MASK_W-1:0]  fired_mask;
    } sched_rsp_t;

    // shadow slot table
    logic [TIME_W-1:0]        period_tab [NUM_TASKS];
    logic                     repeat_tab [NUM_TASKS];
    logic [TIME_W-1:0]        count_tab  [NUM_TASKS];
    logic [PENDING_WIDTH-1:0] runs_tab   [NUM_TASKS];

    sched_rsp_t due_rsp_q[$];

    function automatic sched_rsp_t schedule_outcome(op_t code, logic [SEL_W-1:0] sel,
                                                    logic [TIME_W-1:0] rel,
                                                    logic [TIME_W-1:0] cnt,
                                                    logic per, logic clr);
        sched_rsp_t r;
        logic found;
        r = '0;
        found = 1'b0;
        case (code)
            OP_TICK:
            begin
                for (int s = 0; s < NUM_TASKS; s++)
                begin
                    if (count_tab[s] == COUNT_FIRE)
                    begin
                        // a one-shot slot parks at one
                        if (repeat_tab[s])
                        begin
                            if (runs_tab[s] != RUNS_FULL)
                            begin
                                runs_tab[s] = runs_tab[s] + 1'b1;
                                if (s < MASK_W)
                                    r.fired_mask[s] = 1'b1;
                            end
                            count_tab[s] = period_tab[s];
                        end
                    end
                    else
                        count_tab[s] = count_tab[s] - 1'b1;
                end
            end
            OP_DISPATCH:
            begin
                for (int s = 0; s < NUM_TASKS; s++)
                begin
                    if (!found && runs_tab[s] != '0)
                    begin
                        found = 1'b1;
                        runs_tab[s] = runs_tab[s] - 1'b1;
                        r.task_valid = 1'b1;
                        r.task_index = INDEX_W'(s);
                    end
                end
            end
            OP_LOAD:
            begin
                if (sel < NUM_TASKS)
                begin
                    period_tab[sel] = rel;
                    repeat_tab[sel] = per && (rel != RELOAD_NONE);
                    count_tab[sel]  = cnt;
                    if (clr)
                        runs_tab[sel] = '0;
                end
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_rsp_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_TASKS; s++)
            begin
                period_tab[s] = '0;
                repeat_tab[s] = 1'b0;
                count_tab[s]  = '0;
                runs_tab[s]   = '0;
            end
            due_rsp_q.delete();
            errors = 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_rsp_q.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("unexpected response: valid=%0d index=%0d fired=%h",
                                 task_valid, task_index, fired_mask);
                end
                else
                begin
                    want = due_rsp_q.pop_front();
                    if (want.task_valid !== task_valid || want.task_index !== task_index ||
                        want.fired_mask !== fired_mask)
                    begin
                        errors = errors + 1;
                        if (errors <= 10)
                            $display("mismatch: expected valid=%0d index=%0d fired=%h,",
                                     want.task_valid, want.task_index, want.fired_mask,
                                     " got valid=%0d index=%0d fired=%h",
                                     task_valid, task_index, fired_mask);
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
                due_rsp_q.push_back(schedule_outcome(op_t'(op), slot_sel, reload_value,
                                                     countdown_value, periodic,
                                                     clear_pending));
            outstanding <= due_rsp_q.size();
        end
    end

endmodule

/* test/tick_task_scheduler_test.sv */
module tick_task_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    localparam int unsigned NUM_TASKS     = 4;
    localparam int unsigned PENDING_WIDTH = 8;
    localparam int unsigned HOLD_CYCLES   = 60;    // long response hold-off
    localparam int unsigned IDLE_LIMIT    = 1000;  // watchdog, cycles with no transaction

    typedef struct {
        op_t               code;
        logic [SEL_W-1:0]  sel;
        logic [TIME_W-1:0] rel;
        logic [TIME_W-1:0] cnt;
        logic              per;
        logic              clr;
    } sched_cmd_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    logic [1:0]          op = OP_NOP;
    logic [SEL_W-1:0]    slot_sel = '0;
    logic [TIME_W-1:0]   reload_value = '0;
    logic [TIME_W-1:0]   countdown_value = '0;
    logic                periodic = 1'b0;
    logic                clear_pending = 1'b0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic                task_valid;
    logic [INDEX_W-1:0]  task_index;
    logic [MASK_W-1:0]   fired_mask;

    int                  errors;
    int                  outstanding;

    // flags shared between the sender and the receiver processes
    bit                  calm = 1'b0;      // no idling on either side
    bit                  hold_req = 1'b0;  // ask the receiver for one long hold-off

    tick_task_scheduler #(
        .NUM_TASKS     (NUM_TASKS),
        .PENDING_WIDTH (PENDING_WIDTH)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .op              (op),
        .slot_sel        (slot_sel),
        .reload_value    (reload_value),
        .countdown_value (countdown_value),
        .periodic        (periodic),
        .clear_pending   (clear_pending),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .task_valid      (task_valid),
        .task_index      (task_index),
        .fired_mask      (fired_mask)
    );

    // predicts every accepted command and checks every accepted response
    tick_task_scheduler_check #(
        .NUM_TASKS     (NUM_TASKS),
        .PENDING_WIDTH (PENDING_WIDTH)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .op              (op),
        .slot_sel        (slot_sel),
        .reload_value    (reload_value),
        .countdown_value (countdown_value),
        .periodic        (periodic),
        .clear_pending   (clear_pending),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .task_valid      (task_valid),
        .task_index      (task_index),
        .fired_mask      (fired_mask),
        .errors          (errors),
        .outstanding     (outstanding)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // time values: mostly short so slots fire often, sometimes all ones or full range
    function automatic logic [TIME_W-1:0] pick_time();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return TIME_W'($urandom_range(0, 8));
        else if (r == 7)
            return '1;
        else
            return $urandom;
    endfunction

    // an operation with random don't-care payload, so every payload bit toggles
    function automatic sched_cmd_t plain_cmd(op_t code);
        sched_cmd_t c;
        c.code = code;
        c.sel  = SEL_W'($urandom);
        c.rel  = $urandom;
        c.cnt  = $urandom;
        c.per  = 1'($urandom);
        c.clr  = 1'($urandom);
        return c;
    endfunction

    function automatic sched_cmd_t load_cmd(logic [SEL_W-1:0] sel, logic [TIME_W-1:0] rel,
                                            logic [TIME_W-1:0] cnt, logic per, logic clr);
        sched_cmd_t c;
        c.code = OP_LOAD;
        c.sel  = sel;
        c.rel  = rel;
        c.cnt  = cnt;
        c.per  = per;
        c.clr  = clr;
        return c;
    endfunction

    // weighted mix: ticks and dispatches dominate, loads mostly in range
    function automatic sched_cmd_t random_cmd();
        sched_cmd_t c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            c = plain_cmd(OP_TICK);
        else if (pick < 75)
            c = plain_cmd(OP_DISPATCH);
        else if (pick < 95)
        begin
            c = load_cmd(($urandom_range(0, 7) == 0) ? SEL_W'($urandom_range(4, 7))
                                                     : SEL_W'($urandom_range(0, 3)),
                         pick_time(), pick_time(), ($urandom_range(0, 4) != 0),
                         1'($urandom_range(0, 1)));
        end
        else
            c = plain_cmd(OP_NOP);
        return c;
    endfunction

    // offer one transaction and hold it until accepted; random gaps before it
    task automatic send_cmd(sched_cmd_t c);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        op              <= c.code;
        slot_sel        <= c.sel;
        reload_value    <= c.rel;
        countdown_value <= c.cnt;
        periodic        <= c.per;
        clear_pending   <= c.clr;
        cmd_valid       <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // drop valid and wait until every predicted response has been taken
    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // receiver: random stall bursts, one long hold-off on request, none when calm
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                rsp_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // watchdog: ends the run after a long stretch with no transaction on either channel
    initial
    begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && !((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)))
                idle_cycles++;
            else
                idle_cycles = 0;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, wrap from zero, no operation with all-ones payload
        send_cmd(plain_cmd(OP_DISPATCH));
        send_cmd(plain_cmd(OP_TICK));
        send_cmd(load_cmd('1, '1, '1, 1'b1, 1'b1));
        send_cmd('{OP_NOP, '1, '1, '1, 1'b1, 1'b1});
        // fill the table: fast periodic, period two, reload all ones, one-shot from zero
        send_cmd(load_cmd(3'd0, 32'd1, 32'd1, 1'b1, 1'b1));
        send_cmd(load_cmd(3'd1, 32'd2, 32'd1, 1'b1, 1'b0));
        send_cmd(load_cmd(3'd2, 32'hFFFF_FFFF, 32'd1, 1'b1, 1'b1));
        send_cmd(load_cmd(3'd3, 32'd3, 32'd0, 1'b0, 1'b1));
        // out-of-range slots are ignored
        send_cmd(load_cmd(3'd4, 32'd1, 32'd1, 1'b1, 1'b1));
        send_cmd(load_cmd(3'd7, 32'd0, 32'd1, 1'b1, 1'b1));
        repeat (3) send_cmd(plain_cmd(OP_TICK));
        repeat (4) send_cmd(plain_cmd(OP_DISPATCH));
        // one-shot slot parked at one never fires
        send_cmd(load_cmd(3'd3, 32'd1, 32'd1, 1'b0, 1'b1));
        send_cmd(plain_cmd(OP_TICK));
        // reload zero, then clearing pending runs by a load
        send_cmd(load_cmd(3'd1, 32'd0, 32'd1, 1'b1, 1'b0));
        send_cmd(plain_cmd(OP_TICK));
        send_cmd(load_cmd(3'd0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_cmd(plain_cmd(OP_DISPATCH));
        send_cmd(plain_cmd(OP_DISPATCH));

        // random part one, starting with a long response hold-off while commands keep coming
        hold_req = 1'b1;
        repeat (600) send_cmd(random_cmd());

        // pending saturation: two fast periodic slots ticked far past the count limit
        send_cmd(load_cmd(3'd0, 32'd1, 32'd1, 1'b1, 1'b1));
        send_cmd(load_cmd(3'd1, 32'd1, 32'd1, 1'b1, 1'b1));
        repeat (270) send_cmd(plain_cmd(OP_TICK));
        repeat (20) send_cmd(plain_cmd(OP_DISPATCH));
        send_cmd(load_cmd(3'd0, 32'd5, 32'd2, 1'b1, 1'b1));
        send_cmd(load_cmd(3'd1, 32'd3, 32'd1, 1'b1, 1'b1));

        // sender pauses until the pipeline is empty
        drain();

        // random part two
        repeat (600) send_cmd(random_cmd());

        // last part runs back to back with no idling
        calm = 1'b1;
        repeat (300) send_cmd(random_cmd());

        drain();
        repeat (6) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* tick_task_scheduler.f */
rtl/core/tts_pkg.sv
rtl/core/tts_slot.sv
rtl/core/tick_task_scheduler.sv
test/tick_task_scheduler_check.sv
test/tick_task_scheduler_test.sv
